@@ rtl/kesm_pkg.sv @@
// kesm_pkg: shared types, codes and constants of the key escape sequence matcher
// no dependencies; imported by every module of the block

package kesm_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_KEYS_DEF    = 32;
  localparam int MAX_SEQ_LEN_DEF = 7;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;
  localparam int POS_W      = 3;
  localparam int ELEN_W     = 3;
  localparam int OPC_W      = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] ERASE_RESET  = 8'd127;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE   = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_KEY     = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_WR_BYTE = 2'd2,
    OP_WR_LEN  = 2'd3
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_ERASE = 2'd2
  } kind_e;

  // source of the next result item
  typedef enum logic [1:0] {
    EMIT_BYTE  = 2'd0,
    EMIT_ERASE = 2'd1,
    EMIT_KEY   = 2'd2,
    EMIT_PEND  = 2'd3
  } emit_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      table_wr;
    logic      push;
    logic      scan_start;
    logic      scan_step;
    logic      replay_start;
    logic      emit;
    emit_sel_e sel;
    logic      clr_cnt;
  } kesm_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    cnt_zero;
    logic    is_nl;
    logic    is_erase;
    logic    whole;
    logic    any;
    logic    last_row;
    logic    full;
    logic    rep_last;
    logic    out_free;
  } kesm_sts_t;

endpackage

@@ rtl/key_escape_sequence_matcher.sv @@
// key_escape_sequence_matcher: a key byte ends in a key, in no result or in a replay, set
// by the scan over the table memory at one row per cycle while no whole match waits for
// the result register; a replay emits the buffered bytes in order. newline or erase with
// an empty buffer goes from the decode state into the result register once it is free.
// reset clears control state, entry lengths and config; the table is undefined
// until written. one item is in work at a time; the result register frees input.

module key_escape_sequence_matcher
  import kesm_pkg::*;
#(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // from lowest bit: data_byte[7:0], entry_index[12:8], position[15:13],
  // entry_length[18:16], zero fill
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [OPC_W-1:0]      s_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // value[7:0]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast
);

  kesm_cmd_t cmd;
  kesm_sts_t sts;

  kesm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kesm_datapath #(
    .MAX_KEYS    (MAX_KEYS),
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

@@ rtl/kesm_datapath.sv @@
// kesm_datapath: sequence table memory, entry lengths, pending byte buffer,
// row compare, replay counter, config registers and the result register
// depends on kesm_pkg

module kesm_datapath
  import kesm_pkg::*;
#(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kesm_cmd_t             cmd_i,
  output kesm_sts_t             sts_o,
  // from lowest bit: data_byte, entry_index, position, entry_length
  input  logic [S_DATA_W-1:0]   s_tdata_i,
  // opcode
  input  logic [OPC_W-1:0]      s_tuser_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  // value
  output logic [M_DATA_W-1:0]   m_tdata_o,
  // kind
  output logic [KIND_W-1:0]     m_tuser_o,
  output logic                  m_tlast_o
);

  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int IW = $clog2(MAX_SEQ_LEN);
  localparam int CW = $clog2(MAX_SEQ_LEN + 1);
  localparam int LW = (CW > ELEN_W) ? CW : ELEN_W;

  // latched input item
  opcode_e             op_q;
  logic [BYTE_W-1:0]   dat_q;
  logic [IDX_W-1:0]    idx_q;
  logic [POS_W-1:0]    pos_q;
  logic [ELEN_W-1:0]   elen_q;

  logic [BYTE_W-1:0]   erase_q;
  logic                collapse_q;

  // table: one row per entry, one byte lane per position
  logic [MAX_SEQ_LEN-1:0][BYTE_W-1:0] mem_q [MAX_KEYS];
  logic [MAX_SEQ_LEN-1:0][BYTE_W-1:0] row_q;
  logic [ELEN_W-1:0]   len_q [MAX_KEYS];
  logic [ELEN_W-1:0]   lrow_q;
  logic [KW-1:0]       f_q;
  logic [KW-1:0]       fr_q;
  logic                rd_v_q;
  logic                any_q;

  logic [BYTE_W-1:0]   pend_q [MAX_SEQ_LEN];
  logic [CW-1:0]       cnt_q;
  logic [IW-1:0]       r_q;

  logic                ov_q;
  kind_e               okind_q;
  logic [BYTE_W-1:0]   oval_q;
  logic                olast_q;

  logic                same;
  logic                cur_ok;
  logic                whole;
  logic                collapse_case;
  logic                rep_last;
  logic                idx_ok;
  logic                pos_ok;

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_e'(s_tuser_i);
      dat_q  <= s_tdata_i[7:0];
      idx_q  <= s_tdata_i[12:8];
      pos_q  <= s_tdata_i[15:13];
      elen_q <= s_tdata_i[18:16];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q    <= ERASE_RESET;
      collapse_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ERASE_CHAR: erase_q    <= cfg_data_i;
        CFG_COLLAPSE:   collapse_q <= cfg_data_i[0];
      endcase
    end
  end

  assign idx_ok = ({2'b00, idx_q} < 7'(MAX_KEYS));
  assign pos_ok = ({2'b00, pos_q} < 5'(MAX_SEQ_LEN));

  // table memory: byte write, registered row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.table_wr && op_q == OP_WR_BYTE && idx_ok && pos_ok) begin
      mem_q[KW'(idx_q)][IW'(pos_q)] <= dat_q;
    end
    if (cmd_i.scan_step) begin
      row_q <= mem_q[f_q];
    end
  end

  // entry lengths, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_KEYS; k++) begin
        len_q[k] <= '0;
      end
    end else if (cmd_i.table_wr && op_q == OP_WR_LEN && idx_ok) begin
      len_q[KW'(idx_q)] <= elen_q;
    end
  end

  // scan pointer and row tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q    <= '0;
      fr_q   <= '0;
      lrow_q <= '0;
      rd_v_q <= 1'b0;
      any_q  <= 1'b0;
    end else if (cmd_i.scan_start) begin
      f_q    <= '0;
      rd_v_q <= 1'b0;
      any_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      f_q    <= f_q + KW'(1);
      fr_q   <= f_q;
      lrow_q <= len_q[f_q];
      rd_v_q <= 1'b1;
      any_q  <= any_q | cur_ok;
    end
  end

  // compare the row in hand against the buffered prefix
  always_comb begin
    same = 1'b1;
    for (int p = 0; p < MAX_SEQ_LEN; p++) begin
      if (CW'(p) < cnt_q && row_q[p] != pend_q[p]) begin
        same = 1'b0;
      end
    end
  end

  assign cur_ok = rd_v_q && same && (LW'(lrow_q) >= LW'(cnt_q));
  assign whole  = cur_ok && (LW'(lrow_q) == LW'(cnt_q));

  // pending buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (cnt_q >= CW'(MAX_SEQ_LEN)) begin
        pend_q[0] <= dat_q;
      end else begin
        pend_q[cnt_q[IW-1:0]] <= dat_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.push) begin
      if (cnt_q >= CW'(MAX_SEQ_LEN)) begin
        cnt_q <= CW'(1);
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // replay position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (cmd_i.replay_start) begin
      r_q <= '0;
    end else if (cmd_i.emit && cmd_i.sel == EMIT_PEND) begin
      r_q <= r_q + IW'(1);
    end
  end

  assign collapse_case = collapse_q && cnt_q == CW'(2) && pend_q[0] == pend_q[1];
  assign rep_last      = collapse_case || (CW'(r_q) + CW'(1) == cnt_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (m_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.sel)
        EMIT_BYTE: begin
          okind_q <= KIND_PLAIN;
          oval_q  <= dat_q;
          olast_q <= 1'b1;
        end
        EMIT_ERASE: begin
          okind_q <= KIND_ERASE;
          oval_q  <= '0;
          olast_q <= 1'b1;
        end
        EMIT_KEY: begin
          okind_q <= KIND_KEY;
          oval_q  <= BYTE_W'(fr_q);
          olast_q <= 1'b1;
        end
        EMIT_PEND: begin
          okind_q <= KIND_PLAIN;
          oval_q  <= pend_q[r_q];
          olast_q <= rep_last;
        end
      endcase
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = oval_q;
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = olast_q;

  // status
  always_comb begin
    sts_o          = '0;
    sts_o.op       = op_q;
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.is_nl    = (dat_q == NEWLINE_BYTE);
    sts_o.is_erase = (dat_q == erase_q);
    sts_o.whole    = whole;
    sts_o.any      = any_q | cur_ok;
    sts_o.last_row = rd_v_q && (fr_q == KW'(MAX_KEYS - 1));
    sts_o.full     = (cnt_q >= CW'(MAX_SEQ_LEN));
    sts_o.rep_last = rep_last;
    sts_o.out_free = !ov_q || m_tready_i;
  end

  // buffer never holds more than a full sequence
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SEQ_LEN))
    else $error("pending count above sequence length");

  // a recognized key empties the buffer
  a_key_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.sel == EMIT_KEY |=> cnt_q == '0)
    else $error("buffer not empty after key result");

  // table writes leave the buffer alone
  a_wr_keeps_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.table_wr |=> $stable(cnt_q))
    else $error("table write changed pending count");

endmodule

@@ rtl/kesm_ctrl.sv @@
// kesm_ctrl: controller state machine of the key escape sequence matcher
// depends on kesm_pkg; drives kesm_datapath through command and status structs

module kesm_ctrl
  import kesm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  kesm_sts_t sts_i,
  output kesm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_REPLAY = 2'd3
  } state_e;

  state_e state_q;
  state_e state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_KEY: begin
            // newline or erase with nothing buffered goes out at once
            if (sts_i.cnt_zero && (sts_i.is_nl || sts_i.is_erase)) begin
              if (sts_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.sel  = sts_i.is_nl ? EMIT_BYTE : EMIT_ERASE;
                state_d    = ST_IDLE;
              end
            end else begin
              cmd_o.push       = 1'b1;
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          OP_TIMEOUT: begin
            if (sts_i.cnt_zero) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.replay_start = 1'b1;
              state_d            = ST_REPLAY;
            end
          end
          OP_WR_BYTE, OP_WR_LEN: begin
            cmd_o.table_wr = 1'b1;
            state_d        = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        // hold the matching row until the result register is free
        if (sts_i.whole) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.sel     = EMIT_KEY;
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.last_row) begin
            if (!sts_i.any || sts_i.full) begin
              cmd_o.replay_start = 1'b1;
              state_d            = ST_REPLAY;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_PEND;
          if (sts_i.rep_last) begin
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
    endcase
  end

  // never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted into a full output register");

  // replay only runs over a non-empty buffer
  a_replay_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPLAY |-> !sts_i.cnt_zero)
    else $error("replay with empty buffer");

  // bytes given at once are never buffered
  a_push_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> !(sts_i.cnt_zero && (sts_i.is_nl || sts_i.is_erase)))
    else $error("newline or erase byte pushed into empty buffer");

endmodule
